// File: sv/ftpf_pkg.sv
// Shared types, codes and font table for the text-to-page framebuffer renderer.
`timescale 1ns / 1ps

package ftpf_pkg;

  localparam int PANEL_WIDTH_DEF = 128;
  localparam int PANEL_PAGES_DEF = 8;

  localparam logic [5:0] NO_GLYPH   = 6'd63;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_SET   = 2'd1,
    CMD_PUT   = 2'd2,
    CMD_READ  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ADV_4,
    ADV_6,
    ADV_8,
    ADV_12
  } adv_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_DECODE,
    ST_CLEAR,
    ST_READ,
    ST_NORM,
    ST_DBL,
    ST_DBL_END,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic capture;
    logic sweep;
    logic rd_issue;
    logic rd_take;
    logic cur_load;
    logic adv;
    adv_t adv_sel;
    logic chk;
    logic stop_set;
    logic norm_step;
    logic dbl_step;
  } dp_cmd_t;

  typedef struct packed {
    cmd_t cmd;
    logic stopped;
    logic dbl;
    logic is_space;
    logic known;
    logic fits;
    logic rd_ok;
    logic step_last;
    logic dbl_last;
    logic sweep_last;
  } dp_stat_t;

  // ASCII to font index, lower case folded to upper
  function automatic logic [5:0] glyph_index(input logic [7:0] c);
    logic [7:0] u;
    u = c;
    if (c >= 8'h61 && c <= 8'h7A) u = c - 8'd32;
    if (u >= 8'h30 && u <= 8'h39) return 6'(u - 8'h30);
    if (u >= 8'h41 && u <= 8'h5A) return 6'(u - 8'h41 + 8'd10);
    if (u == 8'h3A) return 6'd36;
    if (u == 8'h2D) return 6'd37;
    if (u == 8'h2E) return 6'd38;
    return NO_GLYPH;
  endfunction

  // Five columns, leftmost in the top byte; bit 0 is the top pixel
  function automatic logic [39:0] font_glyph(input logic [5:0] g);
    logic [39:0] w;
    case (g)
      6'd0:  w = 40'h3E5149453E;
      6'd1:  w = 40'h00427F4000;
      6'd2:  w = 40'h4261514946;
      6'd3:  w = 40'h2141454B31;
      6'd4:  w = 40'h1814127F10;
      6'd5:  w = 40'h2745454539;
      6'd6:  w = 40'h3C4A494930;
      6'd7:  w = 40'h0171090503;
      6'd8:  w = 40'h3649494936;
      6'd9:  w = 40'h064949291E;
      6'd10: w = 40'h7E0909097E;
      6'd11: w = 40'h7F49494936;
      6'd12: w = 40'h3E41414122;
      6'd13: w = 40'h7F4141413E;
      6'd14: w = 40'h7F49494941;
      6'd15: w = 40'h7F09090901;
      6'd16: w = 40'h3E4149493B;
      6'd17: w = 40'h7F0808087F;
      6'd18: w = 40'h00417F4100;
      6'd19: w = 40'h2040415F20;
      6'd20: w = 40'h7F08142241;
      6'd21: w = 40'h7F40404040;
      6'd22: w = 40'h7F0204027F;
      6'd23: w = 40'h7F0204087F;
      6'd24: w = 40'h3E4141413E;
      6'd25: w = 40'h7F09090906;
      6'd26: w = 40'h3E4151215E;
      6'd27: w = 40'h7F09192946;
      6'd28: w = 40'h6649495933;
      6'd29: w = 40'h00017F0100;
      6'd30: w = 40'h3F4040403F;
      6'd31: w = 40'h1F2040201F;
      6'd32: w = 40'h3F4038403F;
      6'd33: w = 40'h6314081463;
      6'd34: w = 40'h0304780403;
      6'd35: w = 40'h7149454341;
      6'd36: w = 40'h0036360000;
      6'd37: w = 40'h0808080808;
      6'd38: w = 40'h0000000060;
      default: w = 40'h0;
    endcase
    return w;
  endfunction

  function automatic logic [7:0] font_col(input logic [5:0] g, input logic [2:0] c);
    logic [39:0] w;
    logic [7:0]  b;
    w = font_glyph(g);
    case (c)
      3'd0:    b = w[39:32];
      3'd1:    b = w[31:24];
      3'd2:    b = w[23:16];
      3'd3:    b = w[15:8];
      3'd4:    b = w[7:0];
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// File: sv/ftpf_ctrl.sv
// Sequencer for the renderer: decodes each request and steps the datapath.
`timescale 1ns / 1ps

module ftpf_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  output logic               done,
  input  ftpf_pkg::dp_stat_t st,
  output ftpf_pkg::dp_cmd_t  cmd
);
  import ftpf_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_INIT: begin
        if (st.sweep_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) state_next = ST_DECODE;
      end
      ST_DECODE: begin
        unique case (st.cmd)
          CMD_CLEAR: state_next = ST_CLEAR;
          CMD_SET:   state_next = ST_DONE;
          CMD_READ:  state_next = st.rd_ok ? ST_READ : ST_DONE;
          CMD_PUT: begin
            if (st.stopped || !st.known) begin
              state_next = ST_DONE;
            end else if (!st.dbl) begin
              state_next = ST_NORM;
            end else begin
              state_next = st.fits ? ST_DBL : ST_DONE;
            end
          end
          default: state_next = ST_DONE;
        endcase
      end
      ST_CLEAR: begin
        if (st.sweep_last) state_next = ST_DONE;
      end
      ST_READ:    state_next = ST_DONE;
      ST_NORM: begin
        if (st.step_last) state_next = ST_DONE;
      end
      ST_DBL: begin
        if (st.dbl_last) state_next = ST_DBL_END;
      end
      ST_DBL_END: state_next = ST_DONE;
      ST_DONE:    state_next = ST_IDLE;
      default:    state_next = ST_INIT;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.adv_sel = ADV_4;
    unique case (state)
      ST_INIT, ST_CLEAR: cmd.sweep = 1'b1;
      ST_IDLE:           cmd.capture = start;
      ST_DECODE: begin
        unique case (st.cmd)
          CMD_SET:  cmd.cur_load = 1'b1;
          CMD_READ: cmd.rd_issue = st.rd_ok;
          CMD_PUT: begin
            if (!st.stopped) begin
              if (!st.dbl) begin
                if (st.is_space) begin
                  cmd.adv     = 1'b1;
                  cmd.adv_sel = ADV_4;
                end else if (!st.known) begin
                  cmd.chk = 1'b1;
                end
              end else begin
                if (st.is_space) begin
                  cmd.adv     = 1'b1;
                  cmd.adv_sel = ADV_8;
                  cmd.chk     = 1'b1;
                end else if (st.known && !st.fits) begin
                  cmd.stop_set = 1'b1;
                end
              end
            end
          end
          default: ;
        endcase
      end
      ST_READ: cmd.rd_take = 1'b1;
      ST_NORM: begin
        cmd.norm_step = 1'b1;
        if (st.step_last) begin
          cmd.adv     = 1'b1;
          cmd.adv_sel = ADV_6;
          cmd.chk     = 1'b1;
        end
      end
      ST_DBL: cmd.dbl_step = 1'b1;
      ST_DBL_END: begin
        cmd.adv     = 1'b1;
        cmd.adv_sel = ADV_12;
      end
      default: ;
    endcase
  end

  assign busy = (state != ST_IDLE);
  assign done = (state == ST_DONE);

`ifndef NO_ASSERTIONS
  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("result strobe outside a request");
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && !done))
    else $error("accepted request did not occupy the block");
  a_done_once: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe longer than one cycle");
`endif

endmodule

// File: sv/ftpf_datapath.sv
// Datapath: request registers, cursor state, framebuffer memory and glyph writer.
`timescale 1ns / 1ps

module ftpf_datapath #(
  parameter int PANEL_WIDTH = ftpf_pkg::PANEL_WIDTH_DEF,
  parameter int PANEL_PAGES = ftpf_pkg::PANEL_PAGES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [1:0]         command,
  input  logic [6:0]         column,
  input  logic [5:0]         row,
  input  logic               scale,
  input  logic [7:0]         char_code,
  input  ftpf_pkg::dp_cmd_t  cmd,
  output ftpf_pkg::dp_stat_t st,
  output logic [7:0]         read_byte,
  output logic [7:0]         cursor_column,
  output logic               line_ended
);
  import ftpf_pkg::*;

  localparam int DEPTH = PANEL_WIDTH * PANEL_PAGES;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [8:0] WIDTH9 = 9'(PANEL_WIDTH);

  // request registers
  cmd_t       in_cmd;
  logic [6:0] in_col;
  logic [5:0] in_row;
  logic       in_scale;
  logic [7:0] in_char;

  // cursor state
  logic [7:0] cursor_x;
  logic [5:0] cursor_row;
  logic       double_scale;
  logic       stopped;

  // sequencing
  logic [2:0]    step;
  logic [3:0]    dcol;
  logic [1:0]    dpage;
  logic [AW-1:0] sweep_addr;

  // write side of the double-scale read-modify-write pipe
  logic          wp_valid;
  logic [AW-1:0] wp_addr;
  logic [7:0]    wp_mask;

  logic [7:0] mem [DEPTH];
  logic [7:0] mem_q;
  logic [7:0] rd_byte;

  logic          we;
  logic [AW-1:0] waddr;
  logic [7:0]    wdata;
  logic          re;
  logic [AW-1:0] raddr;

  function automatic logic [AW-1:0] fb_addr(input logic [2:0] pg, input logic [7:0] cx);
    return AW'(AW'(pg) * AW'(PANEL_WIDTH) + AW'(cx));
  endfunction

  logic [5:0] glyph;
  assign glyph = glyph_index(in_char);

  // normal scale
  logic [8:0] n_x;
  logic       n_en;
  logic [7:0] n_data;
  assign n_x    = {1'b0, cursor_x} + 9'(step);
  assign n_en   = (n_x < WIDTH9) && (cursor_row < 6'(PANEL_PAGES));
  assign n_data = (step < 3'd5) ? font_col(glyph, step) : 8'h00;

  // double scale: each font bit becomes two pixel rows
  logic [7:0]  d_fcol;
  logic [6:0]  d_bits;
  logic [13:0] d_pat;
  logic [23:0] d_word;
  logic [7:0]  d_mask;
  logic [3:0]  d_page;
  logic        d_ok;
  logic [7:0]  d_x;

  always_comb begin
    d_fcol = font_col(glyph, dcol[3:1]);
    d_bits = d_fcol[6:0];
    for (int r = 0; r < 7; r++) begin
      d_pat[2*r]   = d_bits[r];
      d_pat[2*r+1] = d_bits[r];
    end
    d_word = 24'(d_pat) << cursor_row[2:0];
    case (dpage)
      2'd0:    d_mask = d_word[7:0];
      2'd1:    d_mask = d_word[15:8];
      default: d_mask = d_word[23:16];
    endcase
  end

  assign d_page = {1'b0, cursor_row[5:3]} + 4'(dpage);
  assign d_ok   = d_page < 4'(PANEL_PAGES);
  assign d_x    = cursor_x + 8'(dcol);

  // cursor advance with saturation
  logic [8:0] adv_sum;
  logic [7:0] cx_new;
  logic [8:0] delta;

  always_comb begin
    case (cmd.adv_sel)
      ADV_4:   delta = 9'd4;
      ADV_6:   delta = 9'd6;
      ADV_8:   delta = 9'd8;
      default: delta = 9'd12;
    endcase
    adv_sum = {1'b0, cursor_x} + delta;
    if (!cmd.adv) begin
      cx_new = cursor_x;
    end else if (adv_sum[8]) begin
      cx_new = 8'hFF;
    end else begin
      cx_new = adv_sum[7:0];
    end
  end

  // memory port selection
  always_comb begin
    we    = 1'b0;
    waddr = wp_addr;
    wdata = mem_q | wp_mask;
    if (cmd.sweep) begin
      we    = 1'b1;
      waddr = sweep_addr;
      wdata = 8'h00;
    end else if (cmd.norm_step) begin
      we    = n_en;
      waddr = fb_addr(cursor_row[2:0], n_x[7:0]);
      wdata = n_data;
    end else if (wp_valid) begin
      we = 1'b1;
    end
    re    = 1'b0;
    raddr = fb_addr(in_row[2:0], {1'b0, in_col});
    if (cmd.rd_issue) begin
      re = 1'b1;
    end else if (cmd.dbl_step) begin
      re    = d_ok;
      raddr = fb_addr(d_page[2:0], d_x);
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) mem_q <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      in_cmd   <= cmd_t'(command);
      in_col   <= column;
      in_row   <= row;
      in_scale <= scale;
      in_char  <= char_code;
      rd_byte  <= 8'h00;
    end else if (cmd.rd_take) begin
      rd_byte <= mem_q;
    end
    wp_addr <= raddr;
    wp_mask <= d_mask;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_x     <= 8'd0;
      cursor_row   <= 6'd0;
      double_scale <= 1'b0;
      stopped      <= 1'b0;
      step         <= 3'd0;
      dcol         <= 4'd0;
      dpage        <= 2'd0;
      sweep_addr   <= '0;
      wp_valid     <= 1'b0;
    end else begin
      wp_valid <= cmd.dbl_step && d_ok;
      if (cmd.capture) begin
        step       <= 3'd0;
        dcol       <= 4'd0;
        dpage      <= 2'd0;
        sweep_addr <= '0;
      end else begin
        if (cmd.sweep) sweep_addr <= sweep_addr + AW'(1);
        if (cmd.norm_step) step <= step + 3'd1;
        if (cmd.dbl_step) begin
          if (dpage == 2'd2) begin
            dpage <= 2'd0;
            dcol  <= dcol + 4'd1;
          end else begin
            dpage <= dpage + 2'd1;
          end
        end
      end
      if (cmd.cur_load) begin
        cursor_x     <= {1'b0, in_col};
        cursor_row   <= in_row;
        double_scale <= in_scale;
        stopped      <= 1'b0;
      end else begin
        cursor_x <= cx_new;
        if (cmd.stop_set || (cmd.chk && ({1'b0, cx_new} >= WIDTH9))) stopped <= 1'b1;
      end
    end
  end

  assign st.cmd        = in_cmd;
  assign st.stopped    = stopped;
  assign st.dbl        = double_scale;
  assign st.is_space   = (in_char == CHAR_SPACE);
  assign st.known      = (glyph != NO_GLYPH);
  assign st.fits       = ({1'b0, cursor_x} + 9'd12) <= WIDTH9;
  assign st.rd_ok      = ({1'b0, in_col} < 8'(PANEL_WIDTH)) && (in_row < 6'(PANEL_PAGES));
  assign st.step_last  = (step == 3'd5);
  assign st.dbl_last   = (dcol == 4'd9) && (dpage == 2'd2);
  assign st.sweep_last = (sweep_addr == AW'(DEPTH - 1));

  assign read_byte     = rd_byte;
  assign cursor_column = cursor_x;
  assign line_ended    = stopped;

`ifndef NO_ASSERTIONS
  a_wp_follows_read: assert property (@(posedge clk) disable iff (rst)
    wp_valid |-> $past(cmd.dbl_step))
    else $error("framebuffer write-back without a preceding read");
  a_stop_on_put: assert property (@(posedge clk) disable iff (rst)
    $rose(stopped) |-> $past(in_cmd == CMD_PUT))
    else $error("line ended outside a put character request");
  a_one_writer: assert property (@(posedge clk) disable iff (rst)
    !(cmd.sweep && (cmd.norm_step || wp_valid)))
    else $error("clearing sweep overlaps a glyph write");
`endif

endmodule

// File: sv/font_text_to_page_framebuffer.sv
// The result strobe (done) ends every request: a set cursor, an off-panel or on-panel read,
// a put that draws nothing, a normal glyph, a double glyph (30 byte read-modify-writes through
// one memory port) and a clear, which sweeps the framebuffer a byte a cycle. One request at
// a time; busy is high from acceptance until the strobe cycle ends. Results cannot be held
// off by the receiver. Synchronous reset clears the cursor, then the block stays busy while
// it zeroes the framebuffer.
`timescale 1ns / 1ps

module font_text_to_page_framebuffer #(
  parameter int PANEL_WIDTH = ftpf_pkg::PANEL_WIDTH_DEF,
  parameter int PANEL_PAGES = ftpf_pkg::PANEL_PAGES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] command,
  input  logic [6:0] column,
  input  logic [5:0] row,
  input  logic       scale,
  input  logic [7:0] char_code,
  output logic       done,
  output logic [7:0] read_byte,
  output logic [7:0] cursor_column,
  output logic       line_ended
);
  import ftpf_pkg::*;

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_st;

  ftpf_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .st    (dp_st),
    .cmd   (dp_cmd)
  );

  ftpf_datapath #(
    .PANEL_WIDTH (PANEL_WIDTH),
    .PANEL_PAGES (PANEL_PAGES)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .command       (command),
    .column        (column),
    .row           (row),
    .scale         (scale),
    .char_code     (char_code),
    .cmd           (dp_cmd),
    .st            (dp_st),
    .read_byte     (read_byte),
    .cursor_column (cursor_column),
    .line_ended    (line_ended)
  );

endmodule
